### rtl/rle_unit_stream_decoder_unit_assert.svh
// assertion helpers for the rle decoder, clocked on clk, quiet in reset
`ifndef RLE_UNIT_STREAM_DECODER_UNIT_ASSERT_SVH
`define RLE_UNIT_STREAM_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define RLE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rle decoder assertion failed");

// next-cycle implication
`define RLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rle decoder assertion failed");

`endif

### rtl/rle_dec_pkg.sv
package rle_dec_pkg;

  localparam int SIZE_BITS = 24;
  localparam int CNT_W     = 24;
  localparam int WORD_W    = 32;

  localparam logic [1:0] UNIT_CODE_1B = 2'd0;
  localparam logic [1:0] UNIT_CODE_2B = 2'd1;

  typedef enum logic [1:0] {
    PH_CTRL = 2'd0,
    PH_RUN  = 2'd1,
    PH_LIT  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_DATA       = 3'd0,
    ST_DONE       = 3'd1,
    ST_UNALIGNED  = 3'd2,
    ST_SHORT_CTRL = 3'd3,
    ST_SHORT_RUN  = 3'd4,
    ST_SHORT_LIT  = 3'd5,
    ST_OVERRUN    = 3'd6
  } status_t;

  typedef enum logic [0:0] {
    CFG_UNIT_SIZE   = 1'b0,
    CFG_OUTPUT_SIZE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_asset;
    logic       last_of_source;
  } item_t;

  typedef struct packed {
    logic [1:0]           unit_size_code;
    logic [SIZE_BITS-1:0] output_size;
  } cfg_t;

  typedef struct packed {
    phase_t               phase;
    logic [1:0]           byte_in_unit;
    logic [WORD_W-1:0]    word_asm;
    logic [CNT_W-1:0]     op_left;
    logic [SIZE_BITS-1:0] out_done;
    logic [WORD_W-1:0]    src_seen;
    logic                 done_flag;
    logic [CNT_W-1:0]     pend_run;
  } dec_state_t;

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] unit_value;
    logic [CNT_W-1:0]  repeat_count;
    logic [WORD_W-1:0] bytes_consumed;
    logic              finished;
  } result_t;

endpackage

### rtl/rle_dec_step.sv
module rle_dec_step (
  input  rle_dec_pkg::cfg_t       cfg,
  input  rle_dec_pkg::dec_state_t st,
  input  rle_dec_pkg::item_t      item,
  output rle_dec_pkg::dec_state_t st_nxt,
  output logic                    emit,
  output rle_dec_pkg::result_t    res
);
  import rle_dec_pkg::*;

  dec_state_t           s;
  phase_t               phase;
  phase_t               ph_after;
  logic [1:0]           unit_shift;
  logic [2:0]           unit_bytes;
  logic                 unaligned;
  logic [WORD_W-1:0]    seen_inc;
  logic [WORD_W-1:0]    asm_new;
  logic [2:0]           biu_inc;
  logic                 complete;
  logic                 top_bit;
  logic [30:0]          low_bits;
  logic [WORD_W-1:0]    count;
  logic [SIZE_BITS-1:0] rem;
  logic [SIZE_BITS-1:0] rem_units;
  logic                 overrun;
  logic [SIZE_BITS-1:0] run_bytes;
  logic [SIZE_BITS-1:0] done_after;
  logic [CNT_W-1:0]     lit_left;
  logic [CNT_W-1:0]     cnt;
  logic                 fin;

  always_comb begin
    s = st;
    if (item.first_of_asset) begin
      s = '0;
    end

    case (cfg.unit_size_code)
      UNIT_CODE_1B: unit_shift = 2'd0;
      UNIT_CODE_2B: unit_shift = 2'd1;
      default:      unit_shift = 2'd2;
    endcase
    unit_bytes = 3'd1 << unit_shift;
    unaligned  = (cfg.output_size & SIZE_BITS'(unit_bytes - 3'd1)) != '0;

    phase = (s.phase == PH_RUN || s.phase == PH_LIT) ? s.phase : PH_CTRL;

    seen_inc = s.src_seen + 32'd1;
    asm_new  = {s.word_asm[WORD_W-9:0], item.data_byte};
    biu_inc  = {1'b0, s.byte_in_unit} + 3'd1;
    complete = biu_inc >= unit_bytes;

    // control word: top bit of the unit picks run or literal
    case (unit_shift)
      2'd0: begin
        top_bit  = asm_new[7];
        low_bits = {24'd0, asm_new[6:0]};
      end
      2'd1: begin
        top_bit  = asm_new[15];
        low_bits = {16'd0, asm_new[14:0]};
      end
      default: begin
        top_bit  = asm_new[31];
        low_bits = asm_new[30:0];
      end
    endcase
    count = {1'b0, low_bits} + (top_bit ? 32'd3 : 32'd1);

    rem       = (cfg.output_size > s.out_done) ? cfg.output_size - s.out_done : '0;
    rem_units = rem >> unit_shift;
    overrun   = count > WORD_W'(rem_units);

    run_bytes = SIZE_BITS'(s.pend_run) << unit_shift;
    lit_left  = (s.op_left != '0) ? s.op_left - CNT_W'(1) : '0;

    st_nxt     = s;
    emit       = 1'b0;
    fin        = 1'b0;
    res        = '0;
    ph_after   = PH_CTRL;
    done_after = s.out_done;
    cnt        = '0;

    if (!s.done_flag) begin
      if (unaligned) begin
        emit       = 1'b1;
        fin        = 1'b1;
        res.status = ST_UNALIGNED;
      end else if (phase == PH_CTRL && s.byte_in_unit == 2'd0 &&
                   s.out_done >= cfg.output_size) begin
        // nothing left to describe
        emit       = 1'b1;
        fin        = 1'b1;
        res.status = ST_DONE;
      end else begin
        st_nxt.src_seen = seen_inc;
        st_nxt.word_asm = asm_new;
        if (!complete) begin
          st_nxt.byte_in_unit = biu_inc[1:0];
          if (item.last_of_source) begin
            emit = 1'b1;
            fin  = 1'b1;
            unique case (phase)
              PH_CTRL: res.status = ST_SHORT_CTRL;
              PH_RUN:  res.status = ST_SHORT_RUN;
              default: res.status = ST_SHORT_LIT;
            endcase
          end
        end else begin
          st_nxt.byte_in_unit = 2'd0;
          st_nxt.word_asm     = '0;
          unique case (phase)
            PH_CTRL: begin
              if (overrun) begin
                emit       = 1'b1;
                fin        = 1'b1;
                res.status = ST_OVERRUN;
              end else if (top_bit) begin
                st_nxt.pend_run = count[CNT_W-1:0];
                st_nxt.phase    = PH_RUN;
                if (item.last_of_source) begin
                  emit       = 1'b1;
                  fin        = 1'b1;
                  res.status = ST_SHORT_RUN;
                end
              end else begin
                st_nxt.op_left = count[CNT_W-1:0];
                st_nxt.phase   = PH_LIT;
                if (item.last_of_source) begin
                  emit       = 1'b1;
                  fin        = 1'b1;
                  res.status = ST_SHORT_LIT;
                end
              end
            end
            default: begin
              if (phase == PH_RUN) begin
                cnt             = s.pend_run;
                done_after      = s.out_done + run_bytes;
                st_nxt.pend_run = '0;
                ph_after        = PH_CTRL;
              end else begin
                cnt            = CNT_W'(1);
                done_after     = s.out_done + SIZE_BITS'(unit_bytes);
                st_nxt.op_left = lit_left;
                ph_after       = (lit_left == '0) ? PH_CTRL : PH_LIT;
              end
              st_nxt.out_done = done_after;
              st_nxt.phase    = ph_after;
              emit            = 1'b1;
              if (ph_after == PH_CTRL && done_after >= cfg.output_size) begin
                fin              = 1'b1;
                res.status       = ST_DONE;
                res.unit_value   = asm_new;
                res.repeat_count = cnt;
              end else if (item.last_of_source) begin
                // short stream replaces the descriptor this byte completed
                fin        = 1'b1;
                res.status = (ph_after == PH_LIT) ? ST_SHORT_LIT : ST_SHORT_CTRL;
              end else begin
                res.status       = ST_DATA;
                res.unit_value   = asm_new;
                res.repeat_count = cnt;
              end
            end
          endcase
        end
      end
    end

    res.finished       = fin;
    res.bytes_consumed = fin ? st_nxt.src_seen : '0;
    if (fin) begin
      st_nxt.done_flag = 1'b1;
    end
  end

endmodule

### rtl/rle_dec_out_reg.sv
module rle_dec_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  rle_dec_pkg::result_t d,
  input  logic                 out_stall,
  output logic                 out_valid,
  output rle_dec_pkg::result_t q,
  output logic                 free
);
  import rle_dec_pkg::*;

  logic    valid_r;
  result_t q_r;

  // room for a new word when empty or when the held one leaves this cycle
  assign free      = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign q         = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      q_r <= d;
    end
  end

endmodule

### rtl/rle_unit_stream_decoder_unit.sv
// path: an accepted byte goes to the input register, and its result to the result register
// throughput: one compressed byte per cycle unless a held result is stalled, set by the
//   state update between the input register and the result register
// reset: synchronous active-low rst_n clears config, decode state and both valid flags
`include "rle_unit_stream_decoder_unit_assert.svh"

module rle_unit_stream_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_of_asset,
  input  logic        in_last_of_source,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_unit_value,
  output logic [23:0] out_repeat_count,
  output logic [31:0] out_bytes_consumed,
  output logic        out_finished,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [23:0] cfg_wdata
);
  import rle_dec_pkg::*;

  cfg_t       cfg_r;
  logic       in_valid_r;
  item_t      in_item_r;
  dec_state_t st_r;
  dec_state_t st_nxt;
  logic       step_emit;
  result_t    step_res;
  result_t    out_res;
  logic       out_free;
  logic       process;
  logic       take;

  assign cfg_ready = 1'b1;
  assign process   = in_valid_r && out_free;
  assign in_stall  = in_valid_r && !out_free;
  assign take      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_UNIT_SIZE:   cfg_r.unit_size_code <= cfg_wdata[1:0];
        CFG_OUTPUT_SIZE: cfg_r.output_size    <= SIZE_BITS'(cfg_wdata);
        default:         cfg_r <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (take) begin
      in_valid_r <= 1'b1;
    end else if (process) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_item_r <= '{data_byte: in_data_byte, first_of_asset: in_first_of_asset,
                     last_of_source: in_last_of_source};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (process) begin
      st_r <= st_nxt;
    end
  end

  rle_dec_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (in_item_r),
    .st_nxt (st_nxt),
    .emit   (step_emit),
    .res    (step_res)
  );

  rle_dec_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (process && step_emit),
    .d         (step_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .q         (out_res),
    .free      (out_free)
  );

  assign out_status         = out_res.status;
  assign out_unit_value     = out_res.unit_value;
  assign out_repeat_count   = out_res.repeat_count;
  assign out_bytes_consumed = out_res.bytes_consumed;
  assign out_finished       = out_res.finished;

  `RLE_ASSERT_IMPL(a_data_not_final, out_valid && !out_finished,
                   (out_bytes_consumed == 32'd0) && (out_status == ST_DATA))
  `RLE_ASSERT_IMPL(a_stall_only_when_full, in_stall, in_valid_r && out_valid)
  `RLE_ASSERT_IMPL(a_quiet_after_finish,
                   process && st_r.done_flag && !in_item_r.first_of_asset, !step_emit)
  `RLE_ASSERT_NEXT(a_finish_latches, process && step_emit && step_res.finished,
                   st_r.done_flag)

endmodule

### dv/rle_unit_stream_decoder_unit_tb.sv
module rle_unit_stream_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rle_dec_pkg::*;

  localparam logic [1:0] UNIT_CODE_4B   = 2'd2;
  localparam logic [1:0] UNIT_CODE_ALT4B = 2'd3;

  // predicts result descriptors per source byte and holds those not yet seen
  class rle_decode_scoreboard;
    logic [1:0]  unit_code;
    logic [23:0] out_size;
    phase_t      phase;
    int unsigned byte_pos;
    logic [31:0] word_acc;
    logic [23:0] lit_left;
    logic [23:0] bytes_out;
    logic [31:0] src_count;
    bit          asset_over;
    logic [23:0] run_count;
    result_t     descriptors_due[$];
    int          errors;

    function new();
      unit_code = '0;
      out_size  = '0;
      errors    = 0;
      clear_asset();
    endfunction

    function void clear_asset();
      phase      = PH_CTRL;
      byte_pos   = 0;
      word_acc   = '0;
      lit_left   = '0;
      bytes_out  = '0;
      src_count  = '0;
      asset_over = 1'b0;
      run_count  = '0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [23:0] v);
      if (idx == CFG_UNIT_SIZE) unit_code = v[1:0];
      else out_size = v;
    endfunction

    function int pending();
      return descriptors_due.size();
    endfunction

    function void emit(status_t st, logic [31:0] val, logic [23:0] cnt, bit fin);
      result_t r;
      r.status         = st;
      r.unit_value     = val;
      r.repeat_count   = cnt;
      r.bytes_consumed = fin ? src_count : 32'd0;
      r.finished       = fin;
      if (fin) asset_over = 1'b1;
      descriptors_due.insert(descriptors_due.size(), r);
    endfunction

    function void note_byte(logic [7:0] b, bit is_first, bit is_last);
      int unsigned unit;
      logic [63:0] w, high, count, rem;
      logic [31:0] val;
      logic [23:0] cnt;
      if (is_first) clear_asset();
      if (asset_over) return;
      unit = (unit_code == UNIT_CODE_1B) ? 1 : (unit_code == UNIT_CODE_2B) ? 2 : 4;
      if (out_size % unit != 0) begin
        emit(ST_UNALIGNED, '0, '0, 1'b1);
        return;
      end
      // output already complete when a new control word would start
      if (phase == PH_CTRL && byte_pos == 0 && bytes_out >= out_size) begin
        emit(ST_DONE, '0, '0, 1'b1);
        return;
      end
      src_count = src_count + 32'd1;
      word_acc  = {word_acc[23:0], b};
      byte_pos++;
      if (byte_pos < unit) begin
        if (is_last)
          emit(phase == PH_CTRL ? ST_SHORT_CTRL : (phase == PH_RUN ? ST_SHORT_RUN : ST_SHORT_LIT),
               '0, '0, 1'b1);
        return;
      end
      byte_pos = 0;
      w        = {32'd0, word_acc};
      word_acc = '0;
      if (phase == PH_CTRL) begin
        high  = 64'd1 << (8 * unit - 1);
        count = (w & (high - 1)) + (((w & high) != 0) ? 64'd3 : 64'd1);
        rem   = (out_size > bytes_out) ? 64'(out_size - bytes_out) : 64'd0;
        if (count > rem / unit) begin
          emit(ST_OVERRUN, '0, '0, 1'b1);
        end else if ((w & high) != 0) begin
          run_count = count[23:0];
          phase     = PH_RUN;
          if (is_last) emit(ST_SHORT_RUN, '0, '0, 1'b1);
        end else begin
          lit_left = count[23:0];
          phase    = PH_LIT;
          if (is_last) emit(ST_SHORT_LIT, '0, '0, 1'b1);
        end
        return;
      end
      val = w[31:0];
      if (phase == PH_RUN) begin
        cnt       = run_count;
        bytes_out = 24'(bytes_out + cnt * unit);
        run_count = '0;
        phase     = PH_CTRL;
      end else begin
        cnt       = 24'd1;
        bytes_out = 24'(bytes_out + unit);
        if (lit_left > 0) lit_left--;
        if (lit_left == 0) phase = PH_CTRL;
      end
      if (phase == PH_CTRL && bytes_out >= out_size) emit(ST_DONE, val, cnt, 1'b1);
      else if (is_last) emit(phase == PH_LIT ? ST_SHORT_LIT : ST_SHORT_CTRL, '0, '0, 1'b1);
      else emit(ST_DATA, val, cnt, 1'b0);
    endfunction

    function void match_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %h, got %h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [2:0] st, logic [31:0] val, logic [23:0] cnt,
                               logic [31:0] used, logic fin);
      result_t want;
      if (descriptors_due.size() == 0) begin
        $error("unexpected result: status %0d value %h count %0d", st, val, cnt);
        errors++;
        return;
      end
      want = descriptors_due.pop_front();
      match_field("status", 32'(want.status), 32'(st));
      match_field("unit_value", want.unit_value, val);
      match_field("repeat_count", 32'(want.repeat_count), 32'(cnt));
      match_field("bytes_consumed", want.bytes_consumed, used);
      match_field("finished", 32'(want.finished), 32'(fin));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_first_of_asset;
  logic        in_last_of_source;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [31:0] out_unit_value;
  logic [23:0] out_repeat_count;
  logic [31:0] out_bytes_consumed;
  logic        out_finished;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [23:0] cfg_wdata;

  rle_decode_scoreboard sb;
  int bytes_fed = 0;
  bit steady = 1'b0;

  rle_unit_stream_decoder_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_first_of_asset (in_first_of_asset),
    .in_last_of_source (in_last_of_source),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_unit_value    (out_unit_value),
    .out_repeat_count  (out_repeat_count),
    .out_bytes_consumed(out_bytes_consumed),
    .out_finished      (out_finished),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_byte(input logic [7:0] b, input bit is_first, input bit is_last,
                           input bit counted);
    if (!steady && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= b;
    in_first_of_asset <= is_first;
    in_last_of_source <= is_last;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b, is_first, is_last);
    if (counted) bytes_fed++;
  endtask

  // wait for every descriptor, then idle on for words that give none
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [1:0] code, input logic [23:0] osize);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_UNIT_SIZE;
    cfg_wdata <= {22'd0, code};
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(CFG_UNIT_SIZE, {22'd0, code});
    cfg_index <= CFG_OUTPUT_SIZE;
    cfg_wdata <= osize;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(CFG_OUTPUT_SIZE, osize);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_asset(input int unsigned unit, input logic [23:0] osize);
    logic [7:0]  src[$];
    logic [63:0] left_units, lim, count, ctrl, maxc;
    int unsigned kind, ops, cut;
    bit noisy, end_last, is_first, is_last;
    kind       = $urandom_range(0, 99);
    noisy      = (kind < 8) || (osize % unit != 0);
    left_units = 64'(osize / unit);
    lim        = 64'd1 << (8 * unit - 1);
    ops        = 0;
    if (noisy) begin
      repeat ($urandom_range(1, 6)) src.insert(src.size(), 8'($urandom_range(0, 255)));
    end else begin
      while (left_units > 0 && ops < 10 && src.size() < 40) begin
        if (kind < 18 && ops == 0 && left_units + 1 <= lim + 2) begin
          // ask for more units than are left
          count = left_units + 1 + 64'($urandom_range(0, 3));
          if (count > lim + 2) count = lim + 2;
          ctrl = (count >= 3) ? (lim | (count - 3)) : (count - 1);
          for (int i = unit - 1; i >= 0; i--) src.insert(src.size(), ctrl[8*i +: 8]);
          repeat ($urandom_range(0, 3)) src.insert(src.size(), 8'($urandom_range(0, 255)));
          count = left_units;
        end else if (left_units >= 3 && $urandom_range(0, 1) == 1) begin
          maxc = (left_units < lim + 2) ? left_units : lim + 2;
          case ($urandom_range(0, 3))
            0:       count = maxc;
            1:       count = 3 + ({$urandom, $urandom} % (maxc - 2));
            default: count = 64'($urandom_range(3, (maxc < 12) ? 32'(maxc) : 32'd12));
          endcase
          ctrl = lim | (count - 3);
          for (int i = unit - 1; i >= 0; i--) src.insert(src.size(), ctrl[8*i +: 8]);
          repeat (unit) src.insert(src.size(), 8'($urandom_range(0, 255)));
        end else begin
          maxc  = (left_units < 6) ? left_units : 6;
          count = 64'($urandom_range(1, 32'(maxc)));
          ctrl  = count - 1;
          for (int i = unit - 1; i >= 0; i--) src.insert(src.size(), ctrl[8*i +: 8]);
          repeat (count * unit) src.insert(src.size(), 8'($urandom_range(0, 255)));
        end
        left_units = left_units - count;
        ops++;
      end
      if (src.size() == 0) src.insert(src.size(), 8'($urandom_range(0, 255)));
    end
    if (!noisy && kind >= 18 && kind < 40) begin
      // cut short somewhere, usually flagged as the end of the source
      cut = $urandom_range(1, src.size());
      while (src.size() > cut) void'(src.pop_back());
      end_last = ($urandom_range(0, 4) != 0);
    end else begin
      end_last = 1'($urandom_range(0, 1));
    end
    for (int i = 0; i < src.size(); i++) begin
      is_first = (i == 0) && (!noisy || $urandom_range(0, 1) == 1);
      is_last  = (i == src.size() - 1) ? end_last : (noisy && $urandom_range(0, 7) == 0);
      send_byte(src[i], is_first, is_last, 1'b1);
    end
    // extra words after the asset; the block drops them once the asset has finished
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0,
                                              1'($urandom_range(0, 1)), 1'b0);
  endtask

  initial begin : result_sink
    int hold_left;
    bit long_hold_done;
    hold_left      = 0;
    long_hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_result(out_status, out_unit_value, out_repeat_count, out_bytes_consumed,
                        out_finished);
      if (hold_left > 0) begin
        hold_left--;
      end else if (!long_hold_done && bytes_fed >= 300) begin
        // long hold so the block backs up into its input
        hold_left      = 400;
        long_hold_done = 1'b1;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 9);
      end
      out_stall <= (hold_left > 0);
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("rle_unit_stream_decoder_unit_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    logic [1:0]  code;
    logic [23:0] osize;
    int unsigned unit;
    sb = new();
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_data_byte      <= '0;
    in_first_of_asset <= 1'b0;
    in_last_of_source <= 1'b0;
    cfg_valid         <= 1'b0;
    cfg_index         <= CFG_UNIT_SIZE;
    cfg_wdata         <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // nothing to produce
    configure(UNIT_CODE_1B, 24'd0);
    send_byte(8'h5A, 1'b1, 1'b0, 1'b1);
    // size not a multiple of the unit
    configure(UNIT_CODE_2B, 24'd5);
    send_byte(8'h00, 1'b1, 1'b0, 1'b1);
    configure(UNIT_CODE_1B, 24'd8);
    // run of 3, literal of 5, then a dropped word
    send_byte(8'h80, 1'b1, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b0, 1'b1);
    send_byte(8'h04, 1'b0, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0, 1'b1);
    send_byte(8'hAA, 1'b0, 1'b0, 1'b1);
    send_byte(8'h55, 1'b0, 1'b0, 1'b1);
    send_byte(8'h01, 1'b0, 1'b0, 1'b1);
    send_byte(8'hFE, 1'b0, 1'b0, 1'b1);
    send_byte(8'h33, 1'b0, 1'b1, 1'b1);
    // run longer than the output
    send_byte(8'hFF, 1'b1, 1'b0, 1'b1);
    // literal cut off after one unit already went out
    send_byte(8'h02, 1'b1, 1'b0, 1'b1);
    send_byte(8'h11, 1'b0, 1'b0, 1'b1);
    send_byte(8'h22, 1'b0, 1'b1, 1'b1);
    // run control with no value behind it
    send_byte(8'h85, 1'b1, 1'b1, 1'b1);
    configure(UNIT_CODE_4B, 24'hFFFFFC);
    // source ends inside a control word
    send_byte(8'h00, 1'b1, 1'b1, 1'b1);
    // one run filling the whole output
    send_byte(8'h80, 1'b1, 1'b0, 1'b1);
    send_byte(8'h3F, 1'b0, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b0, 1'b1);
    send_byte(8'hFC, 1'b0, 1'b0, 1'b1);
    send_byte(8'hDE, 1'b0, 1'b0, 1'b1);
    send_byte(8'hAD, 1'b0, 1'b0, 1'b1);
    send_byte(8'hBE, 1'b0, 1'b0, 1'b1);
    send_byte(8'hEF, 1'b0, 1'b1, 1'b1);

    while (bytes_fed < 1280) begin
      code = 2'($urandom_range(0, 3));
      unit = (code == UNIT_CODE_1B) ? 1 : (code == UNIT_CODE_2B) ? 2 : 4;
      case ($urandom_range(0, 9))
        0:       osize = 24'd0;
        1:       osize = 24'hFFFFFF;
        2:       osize = 24'($urandom_range(0, 24'hFFFFFF));
        3:       osize = 24'hFFFFFF & ~24'(unit - 1);
        4:       osize = 24'(unit * $urandom_range(1, 40) + $urandom_range(1, 3));
        default: osize = 24'(unit * $urandom_range(1, 40));
      endcase
      if (code == UNIT_CODE_ALT4B && $urandom_range(0, 1) == 0)
        osize = 24'(4 * $urandom_range(1, 20));
      configure(code, osize);
      repeat ($urandom_range(2, 8)) begin
        if (bytes_fed >= 1280) break;
        send_asset(unit, osize);
        if (bytes_fed >= 1200) steady = 1'b1;
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("rle_unit_stream_decoder_unit_tb: done, clean");
    else
      $display("rle_unit_stream_decoder_unit_tb: done, errors");
    $finish;
  end

endmodule
